// File: hw/rtl/rbst_pkg.sv
// types and constants shared by the ray box slab test
package rbst_pkg;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned AXES     = 3;
	localparam int unsigned LANES    = 2 * AXES;
	// dividend is |plane - origin| (at most 32 bits) shifted up by 16
	localparam int unsigned DIV_BITS = 48;
	localparam int unsigned WIDE_W   = 50;

	localparam logic signed [WIDE_W-1:0] WIDE_INF = WIDE_W'(64'sd1 <<< 48);
	localparam logic signed [WIDE_W-1:0] FX_ONE   = WIDE_W'(64'sd65536);
	localparam logic signed [WIDE_W-1:0] S32_MAX  = WIDE_W'(64'sd2147483647);
	localparam logic signed [WIDE_W-1:0] S32_MIN  = WIDE_W'(-64'sd2147483648);

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} rbst_in_t;

	typedef struct packed {
		logic               line_hit;
		logic               ray_hit;
		logic               segment_hit;
		logic signed [31:0] t_enter;
		logic signed [31:0] t_exit;
	} rbst_out_t;

	typedef struct packed {
		logic [31:0]         rem;
		logic [DIV_BITS-1:0] nq;
	} rbst_lane_t;

	typedef struct packed {
		logic [AXES-1:0][31:0] dmag;
		logic [LANES-1:0]      neg;
		logic [AXES-1:0]       par;
		logic [AXES-1:0]       outside;
	} rbst_ctl_t;

endpackage

// File: hw/rtl/ray_box_slab_test_unit.sv
// ray versus axis-aligned box slab test, fully pipelined
// registers from input beat to output beat: prep, divider stages, near/far, combined range, output
// throughput: one beat per cycle unless stalled; six 48-step restoring dividers, one quotient bit a stage
// a stall on the output freezes the whole pipeline, nothing is dropped or repeated
// reset clears all stage valid bits; the data registers are not reset
module ray_box_slab_test_unit
	import rbst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rbst_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output rbst_out_t out_data
);

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// prep: differences, magnitudes, signs
	logic signed [31:0] lo_c [AXES];
	logic signed [31:0] hi_c [AXES];
	logic signed [31:0] org_c [AXES];
	logic signed [31:0] dir_c [AXES];
	rbst_lane_t         lane_c [LANES];
	rbst_ctl_t          ctl_c;

	always_comb begin
		logic signed [32:0] diff;
		logic signed [32:0] plane;
		logic [32:0]        amag;
		lo_c[0] = in_data.box_min_x; lo_c[1] = in_data.box_min_y; lo_c[2] = in_data.box_min_z;
		hi_c[0] = in_data.box_max_x; hi_c[1] = in_data.box_max_y; hi_c[2] = in_data.box_max_z;
		org_c[0] = in_data.origin_x; org_c[1] = in_data.origin_y; org_c[2] = in_data.origin_z;
		dir_c[0] = in_data.dir_x; dir_c[1] = in_data.dir_y; dir_c[2] = in_data.dir_z;
		ctl_c = '0;
		for (int a = 0; a < AXES; a++) begin
			ctl_c.par[a] = (dir_c[a] == 32'sd0);
			ctl_c.outside[a] = ctl_c.par[a] && (org_c[a] < lo_c[a] || org_c[a] > hi_c[a]);
			// parallel axes divide by one, their quotient is ignored
			ctl_c.dmag[a] = ctl_c.par[a] ? 32'd1 :
				(dir_c[a][31] ? 32'(-dir_c[a]) : 32'(dir_c[a]));
			for (int s = 0; s < 2; s++) begin
				plane = (s == 0) ? 33'(lo_c[a]) : 33'(hi_c[a]);
				diff  = plane - 33'(org_c[a]);
				amag  = diff[32] ? 33'(-diff) : 33'(diff);
				lane_c[2*a+s].rem = '0;
				lane_c[2*a+s].nq  = {amag[31:0], 16'h0000};
				ctl_c.neg[2*a+s]  = diff[32] ^ dir_c[a][31];
			end
		end
	end

	// divider stages: index 0 is the prep register
	rbst_lane_t dl_sd  [DIV_BITS+1][LANES];
	rbst_ctl_t  ctl_sd [DIV_BITS+1];
	logic       vld_sd [DIV_BITS+1];
	rbst_lane_t dl_nx  [DIV_BITS][LANES];

	always_comb begin
		logic [31:0] rs;
		logic        ge;
		for (int k = 0; k < DIV_BITS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rs = {dl_sd[k][l].rem[30:0], dl_sd[k][l].nq[DIV_BITS-1]};
				ge = rs >= ctl_sd[k].dmag[l/2];
				dl_nx[k][l].rem = ge ? rs - ctl_sd[k].dmag[l/2] : rs;
				dl_nx[k][l].nq  = {dl_sd[k][l].nq[DIV_BITS-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_BITS; k++) vld_sd[k] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= in_valid;
			for (int k = 0; k < DIV_BITS; k++) vld_sd[k+1] <= vld_sd[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_sd[0] <= ctl_c;
			for (int l = 0; l < LANES; l++) dl_sd[0][l] <= lane_c[l];
			for (int k = 0; k < DIV_BITS; k++) begin
				ctl_sd[k+1] <= ctl_sd[k];
				for (int l = 0; l < LANES; l++) dl_sd[k+1][l] <= dl_nx[k][l];
			end
		end
	end

	// per-axis near and far crossings
	logic signed [WIDE_W-1:0] near_c [AXES];
	logic signed [WIDE_W-1:0] far_c  [AXES];
	logic signed [WIDE_W-1:0] near_s3 [AXES];
	logic signed [WIDE_W-1:0] far_s3  [AXES];
	logic                     empty_s3;
	logic                     v_s3;

	always_comb begin
		logic signed [WIDE_W-1:0] ta;
		logic signed [WIDE_W-1:0] tb;
		logic signed [WIDE_W-1:0] ma;
		logic signed [WIDE_W-1:0] mb;
		for (int a = 0; a < AXES; a++) begin
			ma = WIDE_W'(dl_sd[DIV_BITS][2*a].nq);
			mb = WIDE_W'(dl_sd[DIV_BITS][2*a+1].nq);
			ta = ctl_sd[DIV_BITS].neg[2*a]   ? -ma : ma;
			tb = ctl_sd[DIV_BITS].neg[2*a+1] ? -mb : mb;
			if (ctl_sd[DIV_BITS].par[a]) begin
				near_c[a] = -WIDE_INF;
				far_c[a]  = WIDE_INF;
			end else begin
				near_c[a] = (ta < tb) ? ta : tb;
				far_c[a]  = (ta < tb) ? tb : ta;
			end
		end
	end

	// combined range
	logic signed [WIDE_W-1:0] enter_s4;
	logic signed [WIDE_W-1:0] leave_s4;
	logic                     v_s4;
	logic signed [WIDE_W-1:0] enter_c;
	logic signed [WIDE_W-1:0] leave_c;

	always_comb begin
		enter_c = near_s3[0];
		leave_c = far_s3[0];
		for (int a = 1; a < AXES; a++) begin
			if (near_s3[a] > enter_c) enter_c = near_s3[a];
			if (far_s3[a] < leave_c) leave_c = far_s3[a];
		end
		if (empty_s3) begin
			enter_c = WIDE_INF;
			leave_c = -WIDE_INF;
		end
	end

	// flags and saturation
	logic      v_s5;
	rbst_out_t res_s5;
	rbst_out_t res_c;
	logic      line_c;
	logic      ray_c;

	always_comb begin
		line_c = enter_s4 <= leave_s4;
		ray_c  = line_c && leave_s4 >= 0;
		res_c.line_hit    = line_c;
		res_c.ray_hit     = ray_c;
		res_c.segment_hit = ray_c && enter_s4 <= FX_ONE;
		res_c.t_enter = (enter_s4 > S32_MAX) ? 32'sh7fffffff :
			(enter_s4 < S32_MIN) ? 32'sh80000000 : enter_s4[31:0];
		res_c.t_exit  = (leave_s4 > S32_MAX) ? 32'sh7fffffff :
			(leave_s4 < S32_MIN) ? 32'sh80000000 : leave_s4[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vld_sd[DIV_BITS];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				near_s3[a] <= near_c[a];
				far_s3[a]  <= far_c[a];
			end
			empty_s3 <= |ctl_sd[DIV_BITS].outside;
			enter_s4 <= enter_c;
			leave_s4 <= leave_c;
			res_s5   <= res_c;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

	a_ray_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ray_hit |-> out_data.line_hit)
		else $error("ray hit without line hit");
	a_seg_needs_ray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.segment_hit |-> out_data.ray_hit)
		else $error("segment hit without ray hit");
	a_line_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_hit |-> out_data.t_enter <= out_data.t_exit)
		else $error("line hit with entry above exit");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_s4) && $stable(enter_s4))
		else $error("pipeline moved during stall");

endmodule

// File: tb/tb_ray_box_slab_test_unit.sv
// testbench for the ray versus axis-aligned box slab test unit
`timescale 1ns / 100ps

module tb_ray_box_slab_test_unit;
	import rbst_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	rbst_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	rbst_out_t out_data;

	ray_box_slab_test_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	localparam int unsigned LATENCY     = 52;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam longint      T_INF       = 64'sd1 <<< 62;
	localparam longint      T_ONE       = 64'sd65536;

	rbst_out_t   hit_queue[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_off;
	int unsigned cycle_count;
	int unsigned fail_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// slab test on 64-bit values, axis order x y z
	function automatic rbst_out_t slab_hit(rbst_in_t b);
		rbst_out_t r;
		longint lo[3];
		longint hi[3];
		longint org[3];
		longint dv[3];
		longint enter_t;
		longint exit_t;
		longint ta;
		longint tb;
		bit     empty;
		lo  = '{b.box_min_x, b.box_min_y, b.box_min_z};
		hi  = '{b.box_max_x, b.box_max_y, b.box_max_z};
		org = '{b.origin_x, b.origin_y, b.origin_z};
		dv  = '{b.dir_x, b.dir_y, b.dir_z};
		enter_t = -T_INF;
		exit_t  = T_INF;
		empty   = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (dv[a] == 0) begin
				if (org[a] < lo[a] || org[a] > hi[a])
					empty = 1'b1;
				continue;
			end
			ta = ((lo[a] - org[a]) * T_ONE) / dv[a];
			tb = ((hi[a] - org[a]) * T_ONE) / dv[a];
			if (ta > tb) begin
				longint s;
				s  = ta;
				ta = tb;
				tb = s;
			end
			if (ta > enter_t)
				enter_t = ta;
			if (tb < exit_t)
				exit_t = tb;
		end
		if (empty) begin
			enter_t = T_INF;
			exit_t  = -T_INF;
		end
		r.line_hit    = enter_t <= exit_t;
		r.ray_hit     = r.line_hit && exit_t >= 0;
		r.segment_hit = r.ray_hit && enter_t <= T_ONE;
		r.t_enter     = sat32(enter_t);
		r.t_exit      = sat32(exit_t);
		return r;
	endfunction

	// valid stays up between back-to-back beats, it drops only while idling
	task automatic send_query(rbst_in_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		hit_queue.push_back(slab_hit(q));
	endtask

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off != 0) begin
			out_ready <= 1'b0;
			hold_off  <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hit_queue.size() == 0) begin
				$error("result beat with no expectation");
				fail_count++;
			end else begin
				rbst_out_t e;
				e = hit_queue.pop_front();
				if (out_data.line_hit !== e.line_hit) begin
					$error("line_hit exp %0d got %0d", e.line_hit, out_data.line_hit);
					fail_count++;
				end
				if (out_data.ray_hit !== e.ray_hit) begin
					$error("ray_hit exp %0d got %0d", e.ray_hit, out_data.ray_hit);
					fail_count++;
				end
				if (out_data.segment_hit !== e.segment_hit) begin
					$error("segment_hit exp %0d got %0d", e.segment_hit,
						out_data.segment_hit);
					fail_count++;
				end
				if (out_data.t_enter !== e.t_enter) begin
					$error("t_enter exp %h got %h", e.t_enter, out_data.t_enter);
					fail_count++;
				end
				if (out_data.t_exit !== e.t_exit) begin
					$error("t_exit exp %h got %h", e.t_exit, out_data.t_exit);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** ray_box_slab_test_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
			3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(400000)) - 200000) <<< 8;
		endcase
	endfunction

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(7))
			0: return '0;
			1: return $urandom();
			2: return $urandom_range(1) ? 32'h1 : 32'hffffffff;
			3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(8000)) - 4000) <<< 6;
		endcase
	endfunction

	// box mostly ordered around the origin so the range is often non-empty
	function automatic rbst_in_t rand_query();
		rbst_in_t q;
		logic [31:0] a;
		logic [31:0] b;
		for (int k = 0; k < 3; k++) begin
			a = rand_coord();
			b = rand_coord();
			if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
				logic [31:0] s;
				s = a;
				a = b;
				b = s;
			end
			q[32*(11-k) +: 32] = a;
			q[32*(8-k) +: 32]  = b;
			q[32*(5-k) +: 32]  = $urandom_range(3) == 0 ? rand_coord() :
				32'($signed(a) + ($signed(b) - $signed(a)) / 2 +
				$signed($urandom_range(65536)) - 32768);
			q[32*(2-k) +: 32]  = rand_dir();
		end
		return q;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (hit_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		rbst_in_t q;
		// unit box, ray along +x from the left
		q = '{32'shffff0000, 32'shffff0000, 32'shffff0000, 32'sh10000, 32'sh10000,
			32'sh10000, 32'shfffe0000, 0, 0, 32'sh10000, 0, 0};
		send_query(q);
		// all axes parallel, origin inside: unbounded range
		q.dir_x = 0;
		q.origin_x = 0;
		send_query(q);
		// parallel axis, origin outside: empty range
		q.origin_y = 32'sh20000;
		send_query(q);
		// inverted box with a parallel axis
		q = '{32'sh10000, 0, 0, 32'shffff0000, 32'sh10000, 32'sh10000,
			0, 0, 0, 0, 32'sh10000, 32'sh10000};
		send_query(q);
		// inverted box, all axes crossing
		q.dir_x = 32'sh8000;
		send_query(q);
		// extremes: crossings far beyond the Q16.16 range
		q = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0, 0, 0, 1, 1, 32'hffffffff};
		send_query(q);
		q = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000};
		send_query(q);
		send_query('0);
		send_query('1);
		// box behind the ray and beyond the segment
		q = '{32'sh50000, 0, 0, 32'sh60000, 32'sh10000, 32'sh10000,
			0, 32'sh8000, 32'sh8000, 32'hffff0000, 0, 0};
		send_query(q);
		q.dir_x = 32'sh10000;
		send_query(q);
		q.dir_x = 32'sh60000;
		send_query(q);
		// touching exit at zero and entry at exactly one
		q = '{32'shffff0000, 0, 0, 0, 32'sh10000, 32'sh10000,
			0, 32'sh8000, 32'sh8000, 32'sh10000, 0, 0};
		send_query(q);
		q.box_min_x = 32'sh10000;
		q.box_max_x = 32'sh20000;
		send_query(q);
		drain();
	endtask

	task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (n)
			send_query(rand_query());
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		hold_off <= 400;
		repeat (150)
			send_query(rand_query());
		// sender pauses until everything is back
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		hold_off       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cycle_count    = 0;
		fail_count     = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 62, 0);
		test_random(300, 0, 62);
		test_random(200, 12, 12);
		test_backpressure();
		test_random(100, 0, 0);
		recv_stall_pct = 0;
		drain();
		repeat (LATENCY + 10)
			@(posedge clk);
		if (fail_count == 0 && hit_queue.size() == 0)
			$display("** ray_box_slab_test_unit: PASSED **");
		else
			$display("** ray_box_slab_test_unit: FAILED **");
		$finish;
	end

endmodule
